[sv/mwem_pkg.sv]
// Shared types and constants of the Microwire EEPROM master.
// Used by mwem_cfg, mwem_engine and microwire_eeprom_master; no dependencies.
package mwem_pkg;

  localparam int unsigned MAX_ADDR_BITS = 12;
  localparam int unsigned MAX_DATA_BITS = 16;
  localparam int unsigned MIN_ADDR_BITS = 6;
  localparam int unsigned MIN_DATA_BITS = 8;

  // Width of the send register: header, widest address and widest data.
  localparam int unsigned SEND_W = 3 + MAX_ADDR_BITS + MAX_DATA_BITS;
  localparam int unsigned RECV_W = MAX_DATA_BITS + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ADDR_BITS   = 2'd0,
    CFG_DATA_WIDTH  = 2'd1,
    CFG_HALF_PERIOD = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // Command codes on the input stream.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_WREN  = 2'd2,
    OP_WRDS  = 2'd3
  } op_e;

  // Opcodes sent on the wire after the start bit.
  localparam logic [1:0] WIRE_READ  = 2'b10;
  localparam logic [1:0] WIRE_WRITE = 2'b01;
  localparam logic [1:0] WIRE_EWX   = 2'b00;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_PRE  = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_e;

  // Effective (saturated) configuration.
  typedef struct packed {
    logic [3:0]  addr_bits;
    logic [4:0]  data_width;
    logic [15:0] half_period;
  } cfg_t;

  typedef struct packed {
    logic        start_req;
    op_e         op;
    logic [11:0] address;
    logic [15:0] write_data;
    logic        data_out_line;
  } in_t;

  typedef struct packed {
    logic        chip_select;
    logic        serial_clock;
    logic        data_in_line;
    logic        busy_res;
    logic        read_valid;
    logic [15:0] read_data;
  } res_t;

endpackage

[sv/mwem_cfg.sv]
// Configuration registers of the Microwire EEPROM master.
// Holds the width and timing registers and presents them saturated; uses mwem_pkg.
module mwem_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output mwem_pkg::cfg_t    cfg_o
);
  import mwem_pkg::*;

  logic [3:0]  addr_bits_q;
  logic [4:0]  data_width_q;
  logic [15:0] half_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_bits_q   <= 4'd6;
      data_width_q  <= 5'd16;
      half_period_q <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ADDR_BITS:   addr_bits_q   <= cfg_data_i[3:0];
        CFG_DATA_WIDTH:  data_width_q  <= cfg_data_i[4:0];
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (addr_bits_q < 4'(MIN_ADDR_BITS)) begin
      cfg_o.addr_bits = 4'(MIN_ADDR_BITS);
    end else if (addr_bits_q > 4'(MAX_ADDR_BITS)) begin
      cfg_o.addr_bits = 4'(MAX_ADDR_BITS);
    end else begin
      cfg_o.addr_bits = addr_bits_q;
    end
    if (data_width_q < 5'(MIN_DATA_BITS)) begin
      cfg_o.data_width = 5'(MIN_DATA_BITS);
    end else if (data_width_q > 5'(MAX_DATA_BITS)) begin
      cfg_o.data_width = 5'(MAX_DATA_BITS);
    end else begin
      cfg_o.data_width = data_width_q;
    end
    // A half period of zero behaves as one tick.
    cfg_o.half_period = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
  end

endmodule

[sv/mwem_engine.sv]
// Serial sequencer of the Microwire EEPROM master: phase, bit and tick counters
// and the send and receive shift registers, advanced once per tick; uses mwem_pkg.
module mwem_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mwem_pkg::cfg_t    cfg_i,
  input  mwem_pkg::in_t     in_i,
  output mwem_pkg::res_t    res_o
);
  import mwem_pkg::*;

  phase_e              phase_q, phase_d;
  logic [5:0]          bit_cnt_q, bit_cnt_d;
  logic [15:0]         tick_q, tick_d;
  logic [SEND_W-1:0]   send_q, send_d;
  logic [RECV_W-1:0]   recv_q, recv_d;
  logic                is_read_q, is_read_d;

  logic [16:0]         tick_inc;
  logic                phase_end;
  logic                sample;
  logic                read_valid;
  logic [5:0]          bit_cnt_dec;

  // Command setup.
  logic [11:0]         amask_w;
  logic [15:0]         dmask_w;
  logic [11:0]         addr_sel;
  logic [15:0]         data_sel;
  logic [1:0]          wire_op;
  logic [4:0]          addr_sh;
  logic [4:0]          data_sh;
  logic [SEND_W-1:0]   send_init;
  logic [5:0]          bit_init;

  always_comb begin
    // At the full width the shifted one drops out and the mask becomes all ones.
    amask_w  = (12'd1 << cfg_i.addr_bits) - 12'd1;
    dmask_w  = (16'd1 << cfg_i.data_width) - 16'd1;
    addr_sel = in_i.address & amask_w;
    data_sel = 16'd0;
    wire_op  = WIRE_EWX;
    bit_init = 6'd3 + {2'b00, cfg_i.addr_bits};
    unique case (in_i.op)
      OP_READ: begin
        wire_op  = WIRE_READ;
        bit_init = bit_init + {1'b0, cfg_i.data_width} + 6'd1;
      end
      OP_WRITE: begin
        wire_op  = WIRE_WRITE;
        data_sel = in_i.write_data & dmask_w;
        bit_init = bit_init + {1'b0, cfg_i.data_width};
      end
      OP_WREN: addr_sel = amask_w;
      OP_WRDS: addr_sel = 12'd0;
      default: ;
    endcase
    // Fields are placed MSB-aligned so that the top bit is always the next one out.
    addr_sh   = 5'd28 - {1'b0, cfg_i.addr_bits};
    data_sh   = addr_sh - cfg_i.data_width;
    send_init = {1'b1, wire_op, 28'd0}
              | (SEND_W'(addr_sel) << addr_sh)
              | (SEND_W'(data_sel) << data_sh);
  end

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    tick_d      = tick_q;
    send_d      = send_q;
    recv_d      = recv_q;
    is_read_d   = is_read_q;
    sample      = 1'b0;
    read_valid  = 1'b0;
    tick_inc    = {1'b0, tick_q} + 17'd1;
    phase_end   = tick_inc >= {1'b0, cfg_i.half_period};
    bit_cnt_dec = (bit_cnt_q != 6'd0) ? bit_cnt_q - 6'd1 : 6'd0;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          phase_d   = PH_PRE;
          send_d    = send_init;
          bit_cnt_d = bit_init;
          tick_d    = 16'd0;
          is_read_d = (in_i.op == OP_READ);
        end
      end
      PH_PRE: begin
        tick_d = phase_end ? 16'd0 : tick_inc[15:0];
        if (phase_end) begin
          phase_d = PH_LOW;
          sample  = 1'b1;
        end
      end
      PH_LOW: begin
        tick_d = phase_end ? 16'd0 : tick_inc[15:0];
        if (phase_end) begin
          phase_d = PH_HIGH;
        end
      end
      PH_HIGH: begin
        tick_d = phase_end ? 16'd0 : tick_inc[15:0];
        if (phase_end) begin
          send_d    = {send_q[SEND_W-2:0], 1'b0};
          bit_cnt_d = bit_cnt_dec;
          if (bit_cnt_dec == 6'd0) begin
            phase_d    = PH_IDLE;
            read_valid = is_read_q;
          end else begin
            phase_d = PH_LOW;
            sample  = 1'b1;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // DO is captured at the start of each low phase of a read.
    if (sample && is_read_q) begin
      recv_d = {recv_q[RECV_W-2:0], in_i.data_out_line};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 6'd0;
      tick_q    <= 16'd0;
      send_q    <= '0;
      recv_q    <= '0;
      is_read_q <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      tick_q    <= tick_d;
      send_q    <= send_d;
      recv_q    <= recv_d;
      is_read_q <= is_read_d;
    end
  end

  always_comb begin
    res_o.chip_select  = (phase_d == PH_LOW) || (phase_d == PH_HIGH);
    res_o.serial_clock = (phase_d == PH_PRE) || (phase_d == PH_HIGH);
    res_o.data_in_line = res_o.chip_select & send_d[SEND_W-1];
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.read_valid   = read_valid;
    res_o.read_data    = recv_d[15:0] & dmask_w;
  end

endmodule

[sv/microwire_eeprom_master.sv]
// Top level of the Microwire (93Cxx style) serial EEPROM master.
// Instantiates mwem_cfg and mwem_engine; uses mwem_pkg.
//
// Usage: every word on the slave stream is one tick of the serial engine. It
// carries a command request (start_req, op in tuser, address, write_data) and
// the sampled EEPROM DO level. For each accepted word the block returns exactly
// one word on the master stream with the pin levels (CS, SK, DI) for that tick,
// the busy flag, a read-complete pulse and the current read data.
// A request is taken only while the engine is idle; requests during a command
// are ignored. A command shows one SK pulse with CS low, then start bit, opcode,
// address and, for writes, data, MSB first; a read then clocks in a dummy zero
// and data_width bits. Each SK phase lasts half_period ticks.
// Each result word is registered when its input word is accepted and appears in
// the next cycle. Throughput: one word per cycle unless stalled, as the next
// state is one pass of logic from the state registers into the result register.
// Reset clears the sequencer to idle and loads address width 6, data width 16
// and half period 4. When the receiver stalls, the result register holds its
// word and tready drops until it is taken; the engine does not advance.
// Configuration writes are meant to happen while the engine is idle.
module microwire_eeprom_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: start_req[0], address[12:1], write_data[28:13], data_out_line[29], zero[31:30]
  input  logic [31:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: chip_select[0], serial_clock[1], data_in_line[2], busy_res[3],
  //        read_valid[4], read_data[20:5], zero[23:21]
  output logic [23:0] m_axis_tdata
);
  import mwem_pkg::*;

  cfg_t  cfg;
  in_t   in_word;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  accept;

  // The result register frees up in the same cycle it is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_word.start_req     = s_axis_tdata[0];
    in_word.op            = op_e'(s_axis_tuser);
    in_word.address       = s_axis_tdata[12:1];
    in_word.write_data    = s_axis_tdata[28:13];
    in_word.data_out_line = s_axis_tdata[29];
  end

  mwem_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The engine steps exactly once per accepted word.
  mwem_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .cfg_i  (cfg),
    .in_i   (in_word),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.read_data, out_q.read_valid, out_q.busy_res,
                          out_q.data_in_line, out_q.serial_clock, out_q.chip_select};

endmodule

[verif/mwem_pin_checker.sv]
`timescale 1ns / 100ps
// Pin-level checker for the Microwire EEPROM master: it follows configuration
// writes and accepted input words, predicts each result word and compares it.
// Depends on mwem_pkg; tb_top instantiates it next to the block.
module mwem_pin_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned cmd_count_o,
  output int unsigned read_count_o,
  output int unsigned word_count_o,
  output logic        busy_o
);
  import mwem_pkg::*;

  // Shadow copy of the configuration registers, as written.
  logic [3:0]  aw_reg = 4'd6;
  logic [4:0]  dw_reg = 5'd16;
  logic [15:0] hp_reg = 16'd4;

  // Shadow copy of the serial engine.
  phase_e            ph        = PH_IDLE;
  int unsigned       bits_left = 0;
  int unsigned       ticks     = 0;
  logic [SEND_W-1:0] shifter   = '0;
  logic [RECV_W-1:0] sampled   = '0;
  logic              reading   = 1'b0;

  res_t        pin_words_due[$];
  int unsigned fails = 0;
  int unsigned cmds  = 0;
  int unsigned reads = 0;
  int unsigned words = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    fails++;
    $display("[%0t] result word %0d: %s is %0h, expected %0h", $time, words, what, got, want);
  endtask

  // One tick of the engine: takes the input word, advances the shadow state
  // and returns the pin levels and read data the block must show.
  function automatic res_t next_pins(logic start, op_e op, logic [11:0] addr,
                                     logic [15:0] wdata, logic dout);
    res_t        r;
    int unsigned hp, aw, dw, sent;
    logic [31:0] frame;
    logic [31:0] a;
    logic [1:0]  code;
    r  = '0;
    hp = (hp_reg == 16'd0) ? 1 : hp_reg;
    if (ph == PH_IDLE) begin
      if (start) begin
        // Widths are latched when the command is taken.
        aw      = clamp(aw_reg, MIN_ADDR_BITS, MAX_ADDR_BITS);
        dw      = clamp(dw_reg, MIN_DATA_BITS, MAX_DATA_BITS);
        a       = addr & ((32'd1 << aw) - 1);
        reading = (op == OP_READ);
        case (op)
          OP_READ:  code = WIRE_READ;
          OP_WRITE: code = WIRE_WRITE;
          OP_WREN: begin
            code = WIRE_EWX;
            a    = (32'd1 << aw) - 1;
          end
          default: begin
            code = WIRE_EWX;
            a    = '0;
          end
        endcase
        frame = {29'd0, 1'b1, code};
        frame = (frame << aw) | a;
        sent  = 3 + aw;
        if (op == OP_WRITE) begin
          frame = (frame << dw) | (wdata & ((32'd1 << dw) - 1));
          sent  = sent + dw;
        end
        frame     = frame << (SEND_W - sent);
        shifter   = frame[SEND_W-1:0];
        bits_left = sent + (reading ? dw + 1 : 0);
        ticks     = 0;
        ph        = PH_PRE;
        cmds++;
      end
    end else begin
      ticks++;
      if (ticks >= hp) begin
        ticks = 0;
        case (ph)
          PH_PRE: begin
            ph = PH_LOW;
            if (reading) sampled = {sampled[RECV_W-2:0], dout};
          end
          PH_LOW: ph = PH_HIGH;
          default: begin
            shifter = shifter << 1;
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) begin
              ph           = PH_IDLE;
              r.read_valid = reading;
            end else begin
              ph = PH_LOW;
              if (reading) sampled = {sampled[RECV_W-2:0], dout};
            end
          end
        endcase
      end
    end

    r.busy_res = (ph != PH_IDLE);
    if (ph == PH_PRE) begin
      r.serial_clock = 1'b1;
    end else if (ph != PH_IDLE) begin
      r.chip_select  = 1'b1;
      r.serial_clock = (ph == PH_HIGH);
      r.data_in_line = shifter[SEND_W-1];
    end
    // The mask follows the data width register as it stands now.
    r.read_data = 16'(sampled & ((32'd1 << clamp(dw_reg, MIN_DATA_BITS, MAX_DATA_BITS)) - 1));
    if (r.read_valid) reads++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      aw_reg    = 4'd6;
      dw_reg    = 5'd16;
      hp_reg    = 16'd4;
      ph        = PH_IDLE;
      bits_left = 0;
      ticks     = 0;
      shifter   = '0;
      sampled   = '0;
      reading   = 1'b0;
      pin_words_due.delete();
      fail_count_o <= fails;
      pending_o    <= 0;
      cmd_count_o  <= cmds;
      read_count_o <= reads;
      word_count_o <= words;
      busy_o       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ADDR_BITS:   aw_reg = cfg_data_i[3:0];
          CFG_DATA_WIDTH:  dw_reg = cfg_data_i[4:0];
          CFG_HALF_PERIOD: hp_reg = cfg_data_i;
          default: ;
        endcase
      end

      // Results are matched before the new input is queued, so a stray
      // result is never paired with the word accepted on the same edge.
      if (m_tvalid_i && m_tready_i) begin
        words++;
        if (pin_words_due.size() == 0) begin
          report("unexpected result word", m_tdata_i, 0);
        end else begin
          want = pin_words_due.pop_front();
          if (m_tdata_i[0] != want.chip_select)
            report("chip select", m_tdata_i[0], want.chip_select);
          if (m_tdata_i[1] != want.serial_clock)
            report("serial clock", m_tdata_i[1], want.serial_clock);
          if (m_tdata_i[2] != want.data_in_line)
            report("data in line", m_tdata_i[2], want.data_in_line);
          if (m_tdata_i[3] != want.busy_res)
            report("busy", m_tdata_i[3], want.busy_res);
          if (m_tdata_i[4] != want.read_valid)
            report("read valid", m_tdata_i[4], want.read_valid);
          if (m_tdata_i[20:5] != want.read_data)
            report("read data", m_tdata_i[20:5], want.read_data);
          if (m_tdata_i[23:21] != 3'd0)
            report("padding", m_tdata_i[23:21], 0);
        end
      end

      if (s_tvalid_i && s_tready_i)
        pin_words_due.push_back(next_pins(s_tdata_i[0], op_e'(s_tuser_i), s_tdata_i[12:1],
                                          s_tdata_i[28:13], s_tdata_i[29]));

      fail_count_o <= fails;
      pending_o    <= pin_words_due.size();
      cmd_count_o  <= cmds;
      read_count_o <= reads;
      word_count_o <= words;
      busy_o       <= (ph != PH_IDLE);
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the Microwire EEPROM master testbench: clock, reset, configuration
// writes, the input word stream and the result-side back pressure.
// Depends on mwem_pkg, microwire_eeprom_master and mwem_pin_checker.
module tb_top;
  import mwem_pkg::*;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  cfg_idx_e    cfg_idx       = CFG_ADDR_BITS;
  logic [15:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  op_e         s_axis_tuser  = OP_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;

  int unsigned chk_fails, chk_pending, chk_cmds, chk_reads, chk_words;
  logic        chk_busy;

  // Traffic shaping. The sender pauses between bursts only while gaps_on is
  // set; the receiver follows its stall pattern only while stall_on is set.
  bit          gaps_on    = 1'b0;
  bit          stall_on   = 1'b0;
  int unsigned burst_left = 0;
  int unsigned hold_asks  = 0;
  int unsigned hold_done  = 0;
  int unsigned ticks_fed  = 0;
  int unsigned settings   = 0;

  microwire_eeprom_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mwem_pin_checker pin_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending),
    .cmd_count_o  (chk_cmds),
    .read_count_o (chk_reads),
    .word_count_o (chk_words),
    .busy_o       (chk_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #500_000;
    $display("** microwire_eeprom_master: FAILED **");
    $finish;
  end

  // Receiver. It normally follows a random 16-bit ready pattern, reloaded once
  // used up. When the stimulus asks for a hold-off it drops tready for a long
  // stretch, so the result register fills and the block stalls its input.
  initial begin : receiver
    logic [15:0] pat;
    int unsigned slot;
    pat  = '1;
    slot = 0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_asks) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done++;
      end else begin
        if (slot == 0) pat = 16'($urandom | $urandom);
        m_axis_tready <= !stall_on || pat[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  // Offers one word (one engine tick) and waits until it is taken. The DO
  // line level is random on every tick, so reads return random words. While
  // gaps_on is set, the sender may pause after each burst.
  task automatic put_tick(logic start, op_e op, logic [11:0] addr, logic [15:0] wdata);
    logic        dout;
    int unsigned gap;
    dout = 1'($urandom_range(0, 1));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dout, wdata, addr, start};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_fed++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap        = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Keeps requesting the command until the engine has taken it. The checker's
  // count is registered and lags the engine, so one extra request may land while
  // the engine is busy; the block ignores it.
  task automatic issue(op_e op, logic [11:0] addr, logic [15:0] wdata);
    int unsigned seen;
    seen = chk_cmds;
    while (chk_cmds == seen) put_tick(1'b1, op, addr, wdata);
  endtask

  // Runs the engine to idle with empty ticks, stops the stream and waits for
  // every result word. The engine only moves on accepted words, so once the
  // stream stops and the results are in, the predicted busy flag is exact.
  task automatic settle();
    do begin
      while (chk_busy) put_tick(1'b0, OP_READ, '0, '0);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (chk_pending != 0) @(posedge clk_i);
    end while (chk_busy);
  endtask

  // Writes all three registers, then the unused index, which must be ignored.
  // Only called while the engine is idle and no result is outstanding.
  task automatic write_cfg(logic [15:0] aw, logic [15:0] dw, logic [15:0] hp);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ADDR_BITS;
    cfg_data <= aw;
    @(posedge clk_i);
    cfg_idx  <= CFG_DATA_WIDTH;
    cfg_data <= dw;
    @(posedge clk_i);
    cfg_idx  <= CFG_HALF_PERIOD;
    cfg_data <= hp;
    @(posedge clk_i);
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= 16'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  // Random ticks until n more commands have been taken. Most ticks carry a
  // request; those that arrive while the engine is busy are ignored by it.
  task automatic run_random(int unsigned n, bit long_hold);
    int unsigned goal;
    goal = chk_cmds + n;
    if (long_hold) hold_asks <= hold_asks + 1;
    while (chk_cmds < goal)
      put_tick($urandom_range(0, 3) != 0, op_e'(2'($urandom_range(0, 3))),
               12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: address width 6 and a half period of 4 ticks.
    issue(OP_WREN, 12'h000, 16'h0000);
    settle();

    // Reset widths with the shortest clock phase.
    write_cfg(16'd6, 16'd16, 16'd1);
    issue(OP_READ, 12'hFFF, 16'hFFFF);
    settle();

    // Widest address, narrowest data, back to back.
    write_cfg(16'd12, 16'd8, 16'd1);
    issue(OP_READ, 12'hFFF, 16'hFFFF);
    issue(OP_WRDS, 12'hFFF, 16'hFFFF);
    settle();

    // Widths below range saturate upward; a half period of zero acts as one.
    write_cfg(16'd0, 16'd0, 16'd0);
    issue(OP_WRITE, 12'hFFF, 16'hFFFF);
    issue(OP_READ, 12'h000, 16'h0000);
    settle();

    // Widths above range saturate downward.
    write_cfg(16'd15, 16'd31, 16'd1);
    issue(OP_WRITE, 12'h555, 16'hAAAA);
    settle();

    // Random settings and commands with bursts, gaps and receiver stalls,
    // including a long receiver hold-off.
    gaps_on  = 1'b1;
    stall_on <= 1'b1;
    write_cfg(16'($urandom_range(0, 15)), 16'($urandom_range(0, 31)),
              16'($urandom_range(0, 2)));
    run_random(2, 1'b1);
    settle();

    // A stretch with no idling on either side.
    gaps_on  = 1'b0;
    stall_on <= 1'b0;
    write_cfg(16'($urandom_range(0, 15)), 16'($urandom_range(0, 31)),
              16'($urandom_range(0, 2)));
    run_random(2, 1'b0);
    settle();

    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands (%0d reads returned) in %0d ticks and %0d result words,",
             chk_cmds, chk_reads, ticks_fed, chk_words);
    $display("over %0d settings with saturated widths, half periods 0 to 4 and a long stall.",
             settings);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("** microwire_eeprom_master: PASSED **");
    end else begin
      $display("** microwire_eeprom_master: FAILED **");
    end
    $finish;
  end

endmodule
